/* design/ssplit_pkg.sv */
// ssplit_pkg: shared types, character codes and helpers for the sql statement splitter.
// Used by every module under design/; depends on nothing else.
package ssplit_pkg;

  localparam int POS_BITS     = 16;
  localparam int OUT_POS_BITS = 16;

  typedef logic [POS_BITS-1:0]     pos_t;
  typedef logic [OUT_POS_BITS-1:0] out_pos_t;

  // character codes
  localparam logic [7:0] CH_SEMI      = 8'h3B;
  localparam logic [7:0] CH_BSLASH    = 8'h5C;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_BQUOTE    = 8'h60;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_LOWER_G   = 8'h67;
  localparam logic [7:0] CH_UPPER_G   = 8'h47;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;

  // end kinds
  localparam logic [1:0] END_SEMI    = 2'd0;
  localparam logic [1:0] END_LOWER_G = 2'd1;
  localparam logic [1:0] END_UPPER_G = 2'd2;
  localparam logic [1:0] END_LINE    = 2'd3;

  // continuation codes
  localparam logic [2:0] CONT_IDLE     = 3'd0;
  localparam logic [2:0] CONT_STMT     = 3'd1;
  localparam logic [2:0] CONT_SQ       = 3'd2;
  localparam logic [2:0] CONT_DQ       = 3'd3;
  localparam logic [2:0] CONT_BQ       = 3'd4;
  localparam logic [2:0] CONT_BRACE    = 3'd5;
  localparam logic [2:0] CONT_BRACKET  = 3'd6;
  localparam logic [2:0] CONT_BUILTIN  = 3'd7;

  typedef enum logic [3:0] {
    CLS_OTHER,
    CLS_SPACE,
    CLS_SEMI,
    CLS_BSLASH,
    CLS_SQUOTE,
    CLS_DQUOTE,
    CLS_BQUOTE,
    CLS_LBRACE,
    CLS_RBRACE,
    CLS_LBRACKET,
    CLS_RBRACKET,
    CLS_LOWER_G,
    CLS_UPPER_G
  } cls_t;

  typedef enum logic [7:0] {
    MODE_IDLE     = 8'b0000_0001,
    MODE_STMT     = 8'b0000_0010,
    MODE_SQ       = 8'b0000_0100,
    MODE_DQ       = 8'b0000_1000,
    MODE_BQ       = 8'b0001_0000,
    MODE_BRACE    = 8'b0010_0000,
    MODE_BRACKET  = 8'b0100_0000,
    MODE_BUILTIN  = 8'b1000_0000
  } mode_t;

  // one classified byte on its way from front to back
  typedef struct packed {
    cls_t cls;
    logic eol;
    pos_t pos;
  } entry_t;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    r = CLS_OTHER;
    priority if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) r = CLS_SPACE;
    else if (c == CH_SEMI)     r = CLS_SEMI;
    else if (c == CH_BSLASH)   r = CLS_BSLASH;
    else if (c == CH_SQUOTE)   r = CLS_SQUOTE;
    else if (c == CH_DQUOTE)   r = CLS_DQUOTE;
    else if (c == CH_BQUOTE)   r = CLS_BQUOTE;
    else if (c == CH_LBRACE)   r = CLS_LBRACE;
    else if (c == CH_RBRACE)   r = CLS_RBRACE;
    else if (c == CH_LBRACKET) r = CLS_LBRACKET;
    else if (c == CH_RBRACKET) r = CLS_RBRACKET;
    else if (c == CH_LOWER_G)  r = CLS_LOWER_G;
    else if (c == CH_UPPER_G)  r = CLS_UPPER_G;
    else                       r = CLS_OTHER;
    return r;
  endfunction

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] r;
    unique case (m)
      MODE_IDLE:    r = CONT_IDLE;
      MODE_STMT:    r = CONT_STMT;
      MODE_SQ:      r = CONT_SQ;
      MODE_DQ:      r = CONT_DQ;
      MODE_BQ:      r = CONT_BQ;
      MODE_BRACE:   r = CONT_BRACE;
      MODE_BRACKET: r = CONT_BRACKET;
      MODE_BUILTIN: r = CONT_BUILTIN;
      default:      r = CONT_IDLE;
    endcase
    return r;
  endfunction

  function automatic out_pos_t to_out_pos(input pos_t p);
    return OUT_POS_BITS'(p);
  endfunction

endpackage

/* design/ssplit_front.sv */
// ssplit_front: accepts text bytes, classifies them and stamps the running position.
// Depends on ssplit_pkg; feeds ssplit_queue.
module ssplit_front
  import ssplit_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  text_byte,
  input  logic        last_of_line,
  input  logic        q_full,
  output logic        q_push,
  output entry_t      q_data
);

  pos_t byte_position;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.cls = classify(text_byte);
    q_data.eol = last_of_line;
    q_data.pos = byte_position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (q_push) begin
      byte_position <= byte_position + pos_t'(1);
    end
  end

endmodule

/* design/ssplit_queue.sv */
// ssplit_queue: two-entry queue of classified bytes between front and back.
// Depends on ssplit_pkg.
module ssplit_queue
  import ssplit_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head
);

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");
`endif

endmodule

/* design/ssplit_back.sv */
// ssplit_back: runs the parse mode machine on queued bytes and registers the results.
// Depends on ssplit_pkg; drains ssplit_queue.
module ssplit_back
  import ssplit_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  entry_t      head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        statement_done,
  output logic [1:0]  end_kind,
  output logic [15:0] start_position,
  output logic [15:0] end_position,
  output logic        line_done,
  output logic [2:0]  continuation
);

  mode_t      mode, mode_next;
  logic       pending, pending_next;
  pos_t       start_pos, start_pos_next;
  pos_t       last_end, last_end_next;
  logic       done, consumed, emit;
  logic [1:0] kind;
  pos_t       s_pos, e_pos, p, p1, pm1;
  cls_t       cls;

  assign pop = head_valid && (!out_valid || !out_stall);

  always_comb begin
    cls            = head.cls;
    p              = head.pos;
    p1             = head.pos + pos_t'(1);
    pm1            = head.pos - pos_t'(1);
    mode_next      = mode;
    pending_next   = pending;
    start_pos_next = start_pos;
    last_end_next  = last_end;
    done           = 1'b0;
    consumed       = 1'b0;
    kind           = END_SEMI;
    s_pos          = '0;
    e_pos          = '0;

    // settle a held backslash against this byte
    if (pending) begin
      pending_next = 1'b0;
      if (cls == CLS_LOWER_G || cls == CLS_UPPER_G) begin
        if (mode == MODE_STMT) begin
          done  = 1'b1;
          kind  = (cls == CLS_LOWER_G) ? END_LOWER_G : END_UPPER_G;
          s_pos = start_pos;
          e_pos = pm1;
        end
        mode_next = MODE_IDLE;
        consumed  = 1'b1;
      end else if (mode == MODE_IDLE) begin
        mode_next      = MODE_BUILTIN;
        start_pos_next = pm1;
        last_end_next  = p;
      end
    end

    if (!consumed) begin
      unique case (mode_next)
        MODE_IDLE: begin
          if (cls != CLS_SPACE) begin
            start_pos_next = p;
            unique case (cls)
              CLS_SQUOTE: mode_next = MODE_SQ;
              CLS_DQUOTE: mode_next = MODE_DQ;
              CLS_BSLASH: pending_next = 1'b1;
              CLS_SEMI:   mode_next = MODE_IDLE;
              default:    mode_next = MODE_STMT;
            endcase
          end
        end
        MODE_STMT: begin
          unique case (cls)
            CLS_SEMI: begin
              done      = 1'b1;
              kind      = END_SEMI;
              s_pos     = start_pos_next;
              e_pos     = p;
              mode_next = MODE_IDLE;
            end
            CLS_BSLASH:   pending_next = 1'b1;
            CLS_SQUOTE:   mode_next = MODE_SQ;
            CLS_DQUOTE:   mode_next = MODE_DQ;
            CLS_BQUOTE:   mode_next = MODE_BQ;
            CLS_LBRACE:   mode_next = MODE_BRACE;
            CLS_LBRACKET: mode_next = MODE_BRACKET;
            default:      mode_next = MODE_STMT;
          endcase
        end
        MODE_BUILTIN: begin
          if (cls != CLS_SPACE) last_end_next = p1;
        end
        MODE_SQ:      if (cls == CLS_SQUOTE)   mode_next = MODE_STMT;
        MODE_DQ:      if (cls == CLS_DQUOTE)   mode_next = MODE_STMT;
        MODE_BQ:      if (cls == CLS_BQUOTE)   mode_next = MODE_STMT;
        MODE_BRACE:   if (cls == CLS_RBRACE)   mode_next = MODE_STMT;
        MODE_BRACKET: if (cls == CLS_RBRACKET) mode_next = MODE_STMT;
        default:      mode_next = mode_next;
      endcase
    end

    if (head.eol) begin
      // backslash at line end becomes a one-byte builtin when idle
      if (pending_next) begin
        pending_next = 1'b0;
        if (mode_next == MODE_IDLE) begin
          mode_next      = MODE_BUILTIN;
          start_pos_next = p;
          last_end_next  = p1;
        end
      end
      if (mode_next == MODE_BUILTIN) begin
        done      = 1'b1;
        kind      = END_LINE;
        s_pos     = start_pos_next;
        e_pos     = last_end_next;
        mode_next = MODE_IDLE;
      end
    end

    emit = done || head.eol;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      pending   <= 1'b0;
      start_pos <= '0;
      last_end  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        mode      <= mode_next;
        pending   <= pending_next;
        start_pos <= start_pos_next;
        last_end  <= last_end_next;
      end
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      statement_done <= done;
      end_kind       <= done ? kind : END_SEMI;
      start_position <= done ? to_out_pos(s_pos) : '0;
      end_position   <= done ? to_out_pos(e_pos) : '0;
      line_done      <= head.eol;
      continuation   <= head.eol ? mode_code(mode_next) : CONT_IDLE;
    end
  end

`ifndef SYNTHESIS
  a_pending_mode: assert property (@(posedge clk) disable iff (rst)
    pending |-> (mode == MODE_IDLE || mode == MODE_STMT))
    else $error("pending backslash outside idle or statement mode");
  a_no_builtin_cont: assert property (@(posedge clk) disable iff (rst)
    (out_valid && line_done) |-> (continuation != CONT_BUILTIN))
    else $error("builtin mode carried across a line end");
  a_result_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (statement_done || line_done))
    else $error("result with neither statement nor line end");
  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !statement_done) |-> (end_kind == END_SEMI && start_position == '0))
    else $error("line-only result carries statement fields");
`endif

endmodule

/* design/sql_statement_splitter_top.sv */
// Sustained rate is one text byte per clock while neither side stalls. A byte is written into
// the two-entry queue between the classifying front end and the mode machine, the back end
// takes it, and its result then sits in the result register until the output transfer.
// The back end updates its mode once per byte, which sets the rate. While a result waits and
// the output is stalled the back end takes no bytes, so the queue fills after at most two more
// transfers and the input stalls; either side may stall on its own while the queue absorbs
// the slip. Bytes that end neither a statement nor a line produce no output transfer.
// sql_statement_splitter_top: top level, wires front end, queue and back end.
// Depends on ssplit_pkg, ssplit_front, ssplit_queue and ssplit_back.
module sql_statement_splitter_top
  import ssplit_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  text_byte,
  input  logic        last_of_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        statement_done,
  output logic [1:0]  end_kind,
  output logic [15:0] start_position,
  output logic [15:0] end_position,
  output logic        line_done,
  output logic [2:0]  continuation
);

  logic   q_full, q_push, q_pop, q_head_valid;
  entry_t q_data, q_head;

  ssplit_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .text_byte    (text_byte),
    .last_of_line (last_of_line),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_data)
  );

  ssplit_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  ssplit_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (q_head_valid),
    .head           (q_head),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .statement_done (statement_done),
    .end_kind       (end_kind),
    .start_position (start_position),
    .end_position   (end_position),
    .line_done      (line_done),
    .continuation   (continuation)
  );

endmodule
